// ===== src/mrfr_pkg.sv =====
// shared types and constants of the motor reply frame receiver
package mrfr_pkg;

	localparam logic [7:0] HDR_BYTE = 8'h7A;
	localparam logic [7:0] TRL_BYTE = 8'h7B;
	localparam logic [7:0] ADDR_M1 = 8'h01;
	localparam logic [7:0] ADDR_M2 = 8'h02;
	localparam logic [7:0] KIND_SPEED = 8'h00;
	localparam logic [7:0] KIND_POS = 8'h01;

	localparam logic [3:0] POS_HDR = 4'd0;
	localparam logic [3:0] POS_ADDR = 4'd1;
	localparam logic [3:0] POS_KIND = 4'd2;
	localparam logic [3:0] POS_VAL_FIRST = 4'd3;
	localparam logic [3:0] POS_VAL_LAST = 4'd6;
	localparam logic [3:0] POS_CHK = 4'd7;
	localparam logic [3:0] POS_TRL = 4'd8;

	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int DIV10_SHIFT = 35;
	localparam int QUOT_W = 64 - DIV10_SHIFT;
	localparam logic [31:0] POS_LIMIT = 32'd214748364;

	typedef struct packed {
		logic motor_select;
		logic report_type;
		logic neg;
		logic [31:0] mag;
		logic [31:0] raw;
	} cand_t;

	typedef struct packed {
		logic motor_select;
		logic report_type;
		logic neg;
		logic [QUOT_W-1:0] quot;
		logic [31:0] raw;
	} scaled_t;

endpackage

// ===== src/mrfr_framer.sv =====
// byte framer: header hunt, field capture, trailer and xor check
module mrfr_framer (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  logic [7:0] byte_s1,
	output logic take,
	input  logic cand_ready,
	output logic cand_valid_s2,
	output mrfr_pkg::cand_t cand_s2
);

	logic [3:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] addr_q;
	logic [7:0] kind_q;
	logic [7:0] chk_q;
	logic [31:0] value_q;
	logic en2;
	logic addr_ok;
	logic kind_ok;
	logic frame_ok;
	logic val_neg;
	logic [31:0] val_mag;

	assign en2 = !cand_valid_s2 || cand_ready;
	assign take = valid_s1 && en2;

	assign addr_ok = addr_q inside {mrfr_pkg::ADDR_M1, mrfr_pkg::ADDR_M2};
	assign kind_ok = kind_q inside {mrfr_pkg::KIND_SPEED, mrfr_pkg::KIND_POS};
	assign frame_ok = (pos_q == mrfr_pkg::POS_TRL) && (byte_s1 == mrfr_pkg::TRL_BYTE)
		&& (xor_q == chk_q) && addr_ok && kind_ok;
	assign val_neg = value_q[31];
	assign val_mag = val_neg ? (~value_q + 32'd1) : value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= mrfr_pkg::POS_HDR;
			cand_valid_s2 <= 1'b0;
		end else begin
			if (en2) begin
				cand_valid_s2 <= take && frame_ok;
			end
			if (take) begin
				if (pos_q == mrfr_pkg::POS_HDR) begin
					if (byte_s1 == mrfr_pkg::HDR_BYTE) begin
						pos_q <= mrfr_pkg::POS_ADDR;
					end
				end else if (pos_q == mrfr_pkg::POS_TRL) begin
					pos_q <= mrfr_pkg::POS_HDR;
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			case (pos_q)
				mrfr_pkg::POS_HDR: xor_q <= byte_s1;
				mrfr_pkg::POS_ADDR: begin
					addr_q <= byte_s1;
					xor_q <= xor_q ^ byte_s1;
				end
				mrfr_pkg::POS_KIND: begin
					kind_q <= byte_s1;
					xor_q <= xor_q ^ byte_s1;
				end
				mrfr_pkg::POS_CHK: chk_q <= byte_s1;
				default: begin
					if (pos_q inside {[mrfr_pkg::POS_VAL_FIRST:mrfr_pkg::POS_VAL_LAST]}) begin
						value_q <= {value_q[23:0], byte_s1};
						xor_q <= xor_q ^ byte_s1;
					end
				end
			endcase
		end
		if (en2) begin
			cand_s2.motor_select <= (addr_q == mrfr_pkg::ADDR_M2);
			cand_s2.report_type <= (kind_q == mrfr_pkg::KIND_POS);
			cand_s2.neg <= val_neg;
			cand_s2.mag <= val_mag;
			cand_s2.raw <= value_q;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= mrfr_pkg::POS_TRL)
		else $error("frame position out of range");

	a_cand_from_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cand_valid_s2) |-> $past(pos_q == mrfr_pkg::POS_TRL && take))
		else $error("frame candidate without trailer byte");

endmodule

// ===== src/mrfr_scaler.sv =====
// value stage: divide by ten through a reciprocal multiply, output register
module mrfr_scaler (
	input  logic clk,
	input  logic arst_n,
	input  logic cand_valid_s2,
	input  mrfr_pkg::cand_t cand_s2,
	output logic cand_ready,
	output logic report_valid,
	input  logic report_stall,
	output logic motor_select,
	output logic report_type,
	output logic signed [31:0] report_value
);

	logic valid_s3;
	mrfr_pkg::scaled_t scaled_s3;
	logic en_out;
	logic [63:0] prod;
	logic [31:0] quot_ext;
	logic [31:0] pos_val;

	assign en_out = !report_valid || !report_stall;
	assign cand_ready = !valid_s3 || en_out;
	assign prod = 64'(cand_s2.mag) * 64'(mrfr_pkg::DIV10_RECIP);
	assign quot_ext = 32'(scaled_s3.quot);
	assign pos_val = scaled_s3.neg ? (~quot_ext + 32'd1) : quot_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			report_valid <= 1'b0;
		end else begin
			if (cand_ready) begin
				valid_s3 <= cand_valid_s2;
			end
			if (en_out) begin
				report_valid <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand_ready) begin
			scaled_s3.motor_select <= cand_s2.motor_select;
			scaled_s3.report_type <= cand_s2.report_type;
			scaled_s3.neg <= cand_s2.neg;
			scaled_s3.quot <= prod[63:mrfr_pkg::DIV10_SHIFT];
			scaled_s3.raw <= cand_s2.raw;
		end
		if (en_out && valid_s3) begin
			motor_select <= scaled_s3.motor_select;
			report_type <= scaled_s3.report_type;
			report_value <= scaled_s3.report_type ? signed'(pos_val) : signed'(scaled_s3.raw);
		end
	end

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_type |->
		(report_value <= signed'(mrfr_pkg::POS_LIMIT))
		&& (report_value >= -signed'(mrfr_pkg::POS_LIMIT)))
		else $error("position report outside divided range");

	a_s3_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !en_out |=> valid_s3)
		else $error("stalled value stage lost its item");

endmodule

// ===== src/motor_reply_frame_receiver_top.sv =====
// top level of the motor reply frame receiver
// Usage:
//   rx channel: one received serial byte per item (rx_byte), taken at a
//   rising edge with rx_valid high and rx_stall low. Bytes are dropped until
//   a 0x7A header; the header and the eight bytes after it form a frame.
//   report channel: one item per good frame (trailer 0x7B, xor check byte
//   matches, address 1 or 2, type 0 or 1), taken when report_valid is high
//   and report_stall low. motor_select picks the motor, report_type picks
//   speed (raw) or position (value divided by ten toward zero).
// Pipeline: the trailer byte passes the input register, the framer, the
//   reciprocal multiply and the output register before report_valid rises.
// Throughput: one byte per cycle while rx_stall is low; the framer and the
//   multiply stage each handle one byte or one frame a cycle unless stalled.
// Reset: arst_n clears all valid flags and the frame position, so the block
//   waits for a header; no clearing pass.
// Stall: a report held by report_stall backs up through the value stages;
//   bytes stop once the framer holds a candidate that the value stage cannot
//   take, and rx_stall then rises while a byte waits in the input register.
module motor_reply_frame_receiver_top (
	input  logic clk,
	input  logic arst_n,
	input  logic rx_valid,
	output logic rx_stall,
	input  logic [7:0] rx_byte,
	output logic report_valid,
	input  logic report_stall,
	output logic motor_select,
	output logic report_type,
	output logic signed [31:0] report_value
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic take;
	logic cand_ready;
	logic cand_valid_s2;
	mrfr_pkg::cand_t cand_s2;

	assign rx_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	mrfr_framer u_framer (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.byte_s1(byte_s1),
		.take(take),
		.cand_ready(cand_ready),
		.cand_valid_s2(cand_valid_s2),
		.cand_s2(cand_s2)
	);

	mrfr_scaler u_scaler (
		.clk(clk),
		.arst_n(arst_n),
		.cand_valid_s2(cand_valid_s2),
		.cand_s2(cand_s2),
		.cand_ready(cand_ready),
		.report_valid(report_valid),
		.report_stall(report_stall),
		.motor_select(motor_select),
		.report_type(report_type),
		.report_value(report_value)
	);

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && cand_valid_s2)
		else $error("input stalled with no work pending");

endmodule
